[src/mfek_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfek_pkg
// Shared types and constants of the max-flow block.
// ----------------------------------------------------------------------------
package mfek_pkg;
    localparam int MFEK_MAX_VERTICES = 16;
    localparam int MFEK_CAP_BITS     = 16;
    localparam int FLOW_W            = 20;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_SOLVE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BADE = 2'd1;
    localparam logic [1:0] ST_BADS = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    localparam logic [1:0] REG_COUNT  = 2'd0;
    localparam logic [1:0] REG_SOURCE = 2'd1;
    localparam logic [1:0] REG_SINK   = 2'd2;

    typedef enum logic [4:0] {
        S_CLR,      // clearing pass over the capacity memory
        S_IDLE,
        S_ADD_RD,   // read edge cell
        S_ADD_WR,   // add and write back
        S_CPY_RD,   // copy capacity into residual
        S_CPY_WR,
        S_BFS_INIT,
        S_BFS_POP,
        S_BFS_RD,   // issue residual read u,v
        S_BFS_CHK,
        S_NK_RD,    // bottleneck walk
        S_NK_CHK,
        S_AUG_RD,   // augment walk: read forward
        S_AUG_WF,
        S_AUG_RR,   // read reverse
        S_AUG_WR,
        S_DONE,
        S_OUT
    } t_state;
endpackage

[src/mfek_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfek_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mfek_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

[src/max_flow_edmonds_karp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_flow_edmonds_karp
// Edmonds-Karp max flow over a dense capacity matrix in RAM.
// ----------------------------------------------------------------------------
// Add: read the edge cell, add and write back. Unused types and rejected items go straight to the result.
//   Clear: sweep the capacity RAM. Solve: copy capacity into residual, then per search
//   a breadth-first pass, a bottleneck walk and an augment walk over the path edges.
// Throughput: one item at a time; the next is taken once the result is accepted.
// Reset: after reset a clearing pass zeroes the capacity RAM;
//   no item is taken during it, configuration writes are.
// ----------------------------------------------------------------------------
module max_flow_edmonds_karp
    import mfek_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: req_type[1:0], from_vertex[5:2], to_vertex[9:6], edge_capacity[25:10]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: max_flow[19:0], status[21:20]
    output logic [23:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int MAX_VERTICES = MFEK_MAX_VERTICES;
    localparam int CAP_BITS     = MFEK_CAP_BITS;
    localparam int VB = $clog2(MAX_VERTICES);
    localparam int AB = 2 * VB;
    localparam int RB = CAP_BITS + 1;
    localparam int NB = VB + 1;
    localparam logic [CAP_BITS-1:0] CAP_MAX = {CAP_BITS{1'b1}};
    localparam logic [FLOW_W-1:0]   FLOW_SAT = {FLOW_W{1'b1}};
    localparam logic [FLOW_W+1:0]   FLOW_SATW = {2'b00, FLOW_SAT};

    // configuration
    logic [4:0] r_count;
    logic [3:0] r_src, r_snk;
    logic       wr_en;
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd16; r_src <= 4'd0; r_snk <= 4'd1;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_COUNT:  r_count <= pwdata[4:0];
                REG_SOURCE: r_src   <= pwdata[3:0];
                REG_SINK:   r_snk   <= pwdata[3:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            REG_COUNT:  prdata = {27'd0, r_count};
            REG_SOURCE: prdata = {28'd0, r_src};
            REG_SINK:   prdata = {28'd0, r_snk};
            default:    prdata = 32'd0;
        endcase
    end

    // active vertex count, saturated at MAX_VERTICES
    logic [NB-1:0] n_act;
    always_comb begin
        if (32'(r_count) > MAX_VERTICES) n_act = NB'(MAX_VERTICES);
        else n_act = NB'(r_count);
    end

    // item fields
    logic [1:0]  in_req;
    logic [3:0]  in_from, in_to;
    logic [15:0] in_cap;
    assign in_req  = s_axis_tdata[1:0];
    assign in_from = s_axis_tdata[5:2];
    assign in_to   = s_axis_tdata[9:6];
    assign in_cap  = s_axis_tdata[25:10];

    t_state r_state, n_state;
    logic [AB-1:0] r_cnt;         // sweep counter / edge address
    logic [VB-1:0] r_u, r_v, r_cur;
    logic [NB-1:0] r_head, r_tail;
    logic [RB-1:0] r_neck;
    logic [FLOW_W+1:0] r_total;   // saturates at FLOW_SAT
    logic [FLOW_W-1:0] r_flow;
    logic [1:0]    r_stat;
    logic [15:0]   r_add;
    logic [MAX_VERTICES-1:0] r_pvalid;
    logic [VB-1:0] r_parent [MAX_VERTICES];
    logic [VB-1:0] r_queue  [MAX_VERTICES];
    logic          r_ovalid;
    logic          r_clr_rsp;     // clearing pass was started by a clear item

    // memories
    logic          cap_we, res_we;
    logic [AB-1:0] cap_addr, res_addr;
    logic [CAP_BITS-1:0] cap_wd, cap_rd;
    logic [RB-1:0] res_wd, res_rd;
    mfek_ram #(.WIDTH(CAP_BITS), .DEPTH(1 << AB)) u_cap (
        .i_clk(i_clk), .i_we(cap_we), .i_addr(cap_addr), .i_wdata(cap_wd), .o_rdata(cap_rd));
    mfek_ram #(.WIDTH(RB), .DEPTH(1 << AB)) u_res (
        .i_clk(i_clk), .i_we(res_we), .i_addr(res_addr), .i_wdata(res_wd), .o_rdata(res_rd));

    logic take;
    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign take = s_axis_tvalid && s_axis_tready;
    logic [VB-1:0] par_cur;
    assign par_cur = r_parent[r_cur];
    logic [CAP_BITS:0] sum;       // shared adder for add items
    assign sum = {1'b0, cap_rd} + {{(CAP_BITS+1-16){1'b0}}, r_add};
    logic last_cnt;
    assign last_cnt = (r_cnt == {AB{1'b1}});

    function automatic logic [RB-1:0] cap_rd_ext(input logic [CAP_BITS-1:0] c);
        cap_rd_ext = {1'b0, c};
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (last_cnt) n_state = r_clr_rsp ? S_DONE : S_IDLE;
            S_IDLE: if (take) begin
                if (in_req == REQ_ADD) begin
                    if (NB'(in_from) >= n_act || NB'(in_to) >= n_act) n_state = S_DONE;
                    else n_state = S_ADD_RD;
                end else if (in_req == REQ_SOLVE) begin
                    if (NB'(r_src) >= n_act || NB'(r_snk) >= n_act || r_src == r_snk)
                        n_state = S_DONE;
                    else n_state = S_CPY_RD;
                end else if (in_req == REQ_CLEAR) n_state = S_CLR;
                else n_state = S_DONE;
            end
            S_ADD_RD:  n_state = S_ADD_WR;
            S_ADD_WR:  n_state = S_DONE;
            S_CPY_RD:  n_state = S_CPY_WR;
            S_CPY_WR:  n_state = last_cnt ? S_BFS_INIT : S_CPY_RD;
            S_BFS_INIT: n_state = S_BFS_POP;
            S_BFS_POP: n_state = (r_head < r_tail) ? S_BFS_RD : S_DONE;
            S_BFS_RD:  n_state = S_BFS_CHK;
            S_BFS_CHK: begin
                if (!r_pvalid[r_v] && res_rd != '0 && r_v == r_snk[VB-1:0])
                    n_state = S_NK_RD;
                else if (NB'(r_v) + 1'b1 >= n_act) n_state = S_BFS_POP;
                else n_state = S_BFS_RD;
            end
            S_NK_RD:   n_state = S_NK_CHK;
            S_NK_CHK:  n_state = (par_cur == r_src[VB-1:0]) ? S_AUG_RD : S_NK_RD;
            S_AUG_RD:  n_state = S_AUG_WF;
            S_AUG_WF:  n_state = S_AUG_RR;
            S_AUG_RR:  n_state = S_AUG_WR;
            S_AUG_WR:  n_state = (par_cur == r_src[VB-1:0]) ? S_BFS_INIT : S_AUG_RD;
            S_DONE:    n_state = S_OUT;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        cap_we = 1'b0; cap_addr = r_cnt; cap_wd = '0;
        res_we = 1'b0; res_addr = r_cnt; res_wd = cap_rd_ext(cap_rd);
        case (r_state)
            S_CLR: cap_we = 1'b1;
            S_ADD_WR: begin
                cap_we = 1'b1;
                cap_wd = sum[CAP_BITS] ? CAP_MAX : sum[CAP_BITS-1:0];
            end
            S_CPY_WR: res_we = 1'b1;
            S_BFS_RD: res_addr = {r_u, r_v};
            S_NK_RD, S_AUG_RD: res_addr = {par_cur, r_cur};
            S_AUG_WF: begin
                res_addr = {par_cur, r_cur}; res_we = 1'b1; res_wd = res_rd - r_neck;
            end
            S_AUG_RR: res_addr = {r_cur, par_cur};
            S_AUG_WR: begin
                res_addr = {r_cur, par_cur}; res_we = 1'b1; res_wd = res_rd + r_neck;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR; r_cnt <= '0; r_ovalid <= 1'b0; r_total <= '0;
            r_clr_rsp <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLR: r_cnt <= r_cnt + 1'b1;
                S_IDLE: if (take) begin
                    r_flow <= '0; r_add <= in_cap;
                    r_clr_rsp <= (in_req == REQ_CLEAR);
                    r_cnt <= (in_req == REQ_ADD) ? {in_from[VB-1:0], in_to[VB-1:0]} : '0;
                    if (in_req == REQ_ADD &&
                        (NB'(in_from) >= n_act || NB'(in_to) >= n_act)) r_stat <= ST_BADE;
                    else if (in_req == REQ_SOLVE &&
                        (NB'(r_src) >= n_act || NB'(r_snk) >= n_act)) r_stat <= ST_BADS;
                    else r_stat <= ST_OK;
                    // a valid solve restarts the total; a rejected one keeps it
                    if (in_req == REQ_SOLVE && NB'(r_src) < n_act && NB'(r_snk) < n_act)
                        r_total <= '0;
                end
                S_ADD_WR: if (sum[CAP_BITS]) r_stat <= ST_SAT;
                S_CPY_WR: r_cnt <= r_cnt + 1'b1;
                S_BFS_INIT: begin
                    r_pvalid <= MAX_VERTICES'(1) << r_src[VB-1:0];
                    r_queue[0] <= r_src[VB-1:0];
                    r_head <= '0; r_tail <= NB'(1);
                end
                S_BFS_POP: begin
                    r_u <= r_queue[r_head[VB-1:0]];
                    r_head <= r_head + 1'b1; r_v <= '0;
                end
                S_BFS_CHK: begin
                    if (!r_pvalid[r_v] && res_rd != '0) begin
                        r_pvalid[r_v] <= 1'b1;
                        r_parent[r_v] <= r_u;
                        if (r_v == r_snk[VB-1:0]) begin
                            r_cur <= r_v; r_neck <= {RB{1'b1}};
                        end else if (32'(r_tail) < MAX_VERTICES) begin
                            r_queue[r_tail[VB-1:0]] <= r_v;
                            r_tail <= r_tail + 1'b1;
                        end
                    end
                    r_v <= r_v + 1'b1;
                end
                S_NK_CHK: begin
                    if (res_rd < r_neck) r_neck <= res_rd;
                    r_cur <= (par_cur == r_src[VB-1:0]) ? r_snk[VB-1:0] : par_cur;
                end
                S_AUG_WR: begin
                    r_cur <= par_cur;
                    if (par_cur == r_src[VB-1:0]) begin
                        if (r_total + (FLOW_W+2)'(r_neck) > FLOW_SATW) r_total <= FLOW_SATW;
                        else r_total <= r_total + (FLOW_W+2)'(r_neck);
                    end
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
            // solve result: latch flow when the search finds no path
            if (r_state == S_BFS_POP && r_head >= r_tail) r_flow <= r_total[FLOW_W-1:0];
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_stat, r_flow};
endmodule

[src/mfek_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfek_checker
// Port-level checks of the max-flow block.
// ----------------------------------------------------------------------------
module mfek_checker
    import mfek_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // no new item while a result waits
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready with pending result");
    // an accepted item blocks input next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready) else $error("ready after accept");
    // nonzero flow only with status ok
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[21:20] != ST_OK) |-> m_axis_tdata[19:0] == 20'd0)
        else $error("flow with error status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule

bind max_flow_edmonds_karp mfek_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Edmonds-Karp max-flow block. A directed table
// covers the corner cases. Random phases with fresh register settings follow.
// Every result is compared with a bench-side model or with the table's own value.
// ----------------------------------------------------------------------------
module testbench;
    import mfek_pkg::*;

    localparam int  NV        = MFEK_MAX_VERTICES;
    localparam int  CAP_MAX   = (1 << MFEK_CAP_BITS) - 1;
    localparam int  FLOW_SAT  = (1 << FLOW_W) - 1;
    localparam int  LIMIT     = 8000000;
    localparam int  N_PHASES  = 15;
    localparam int  PER_PHASE = 60;

    typedef struct packed {
        logic [19:0] flow;
        logic [1:0]  status;
    } t_flow_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  req;
        logic [3:0]  from_v;
        logic [3:0]  to_v;
        logic [15:0] cap;
        bit          known;
        t_flow_res   res;
        logic [1:0]  reg_idx;
        logic [4:0]  reg_val;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    max_flow_edmonds_karp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bench copy of the block state and registers
    logic [15:0] cap_mem [NV*NV];
    logic [4:0]  cfg_count;
    logic [3:0]  cfg_source;
    logic [3:0]  cfg_sink;

    t_flow_res   pending_q[$];
    t_stim_row   table_q[$];
    int          fail_cnt = 0;
    int          got_cnt = 0;
    int          solve_cnt = 0;
    int          sat_cnt = 0;
    int          bad_cnt = 0;
    int          cycle_cnt = 0;
    bit          calm = 1'b0;   // no idling on either side while set

    // Edmonds-Karp over the bench copy of the capacity matrix
    function automatic int solve_flow(int n, int s, int t);
        int  res [NV*NV];
        int  par [NV];
        bit  seen [NV];
        int  q [NV];
        int  head, tail, u, cur, prv, neck, total;
        bit  found;
        total = 0;
        for (int i = 0; i < NV*NV; i++) res[i] = int'(cap_mem[i]);
        forever begin
            for (int i = 0; i < NV; i++) seen[i] = 1'b0;
            seen[s] = 1'b1;
            q[0] = s;
            head = 0;
            tail = 1;
            found = 1'b0;
            while (head < tail && !found) begin
                u = q[head];
                head++;
                for (int v = 0; v < n; v++) begin
                    if (!found && !seen[v] && res[u*NV+v] > 0) begin
                        seen[v] = 1'b1;
                        par[v] = u;
                        if (v == t) found = 1'b1;
                        else if (tail < NV) begin
                            q[tail] = v;
                            tail++;
                        end
                    end
                end
            end
            if (!found) break;
            neck = 32'h7fffffff;
            cur = t;
            while (cur != s) begin
                prv = par[cur];
                if (res[prv*NV+cur] < neck) neck = res[prv*NV+cur];
                cur = prv;
            end
            cur = t;
            while (cur != s) begin
                prv = par[cur];
                res[prv*NV+cur] -= neck;
                res[cur*NV+prv] += neck;
                cur = prv;
            end
            total += neck;
        end
        return (total > FLOW_SAT) ? FLOW_SAT : total;
    endfunction

    // Apply one item to the bench state and return its expected result
    function automatic t_flow_res predict_item(logic [1:0] req, logic [3:0] fv,
                                               logic [3:0] tv, logic [15:0] cap);
        t_flow_res r;
        int        n, sum;
        r = '{flow: '0, status: ST_OK};
        n = (cfg_count > NV) ? NV : int'(cfg_count);
        if (req == REQ_ADD) begin
            if (fv >= n || tv >= n) begin
                r.status = ST_BADE;
            end else begin
                sum = int'(cap_mem[fv*NV+tv]) + int'(cap);
                if (sum > CAP_MAX) begin
                    cap_mem[fv*NV+tv] = 16'(CAP_MAX);
                    r.status = ST_SAT;
                end else begin
                    cap_mem[fv*NV+tv] = 16'(sum);
                end
            end
        end else if (req == REQ_SOLVE) begin
            if (cfg_source >= n || cfg_sink >= n) r.status = ST_BADS;
            else if (cfg_source != cfg_sink)
                r.flow = 20'(solve_flow(n, int'(cfg_source), int'(cfg_sink)));
        end else if (req == REQ_CLEAR) begin
            for (int i = 0; i < NV*NV; i++) cap_mem[i] = '0;
        end
        return r;
    endfunction

    // Watchdog on the whole run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT) begin
            $display("max_flow_edmonds_karp: mismatch");
            $finish;
        end
    end

    // Hand one item to the block; predict it at the accepting edge
    task automatic send_item(logic [1:0] req, logic [3:0] fv, logic [3:0] tv,
                             logic [15:0] cap, bit known, t_flow_res tab_res);
        int        gap;
        t_flow_res r;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, cap, tv, fv, req};
        do @(posedge i_clk); while (!s_axis_tready);
        r = predict_item(req, fv, tv, cap);
        pending_q.push_back(known ? tab_res : r);
        if (req == REQ_SOLVE) solve_cnt++;
    endtask

    // Hold the sender until every expected result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup then access cycle; block must be idle
    task automatic write_reg(logic [1:0] idx, logic [4:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {27'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_COUNT:  cfg_count  = val;
            REG_SOURCE: cfg_source = val[3:0];
            default:    cfg_sink   = val[3:0];
        endcase
    endtask

    task automatic add_row(t_row_kind kind, logic [1:0] req, logic [3:0] fv, logic [3:0] tv,
                           logic [15:0] cap, bit known, logic [19:0] fl, logic [1:0] st);
        t_stim_row row;
        row.kind = kind;
        row.req = req;
        row.from_v = fv;
        row.to_v = tv;
        row.cap = cap;
        row.known = known;
        row.res = '{flow: fl, status: st};
        row.reg_idx = req;
        row.reg_val = {1'b0, cap[3:0]} | {cap[4], 4'b0};
        table_q.push_back(row);
    endtask

    // Result side: random stalls, field-by-field compare with the oldest expectation
    initial begin
        int        stall;
        t_flow_res want;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got_cnt++;
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: flow %0d status %0d",
                       m_axis_tdata[19:0], m_axis_tdata[21:20]);
                fail_cnt++;
            end else begin
                want = pending_q.pop_front();
                if (m_axis_tdata[19:0] !== want.flow) begin
                    $error("max_flow: expected %0d, got %0d", want.flow, m_axis_tdata[19:0]);
                    fail_cnt++;
                end
                if (m_axis_tdata[21:20] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[21:20]);
                    fail_cnt++;
                end
                if (want.status == ST_SAT) sat_cnt++;
                if (want.status == ST_BADE || want.status == ST_BADS) bad_cnt++;
            end
        end
    end

    initial begin
        int         n, pick, cnt_v;
        logic [1:0] req;
        logic [3:0] fv, tv;
        logic [15:0] cap;
        t_flow_res  none;
        none = '{flow: '0, status: ST_OK};
        for (int i = 0; i < NV*NV; i++) cap_mem[i] = '0;
        cfg_count = 5'd16;
        cfg_source = 4'd0;
        cfg_sink = 4'd1;

        // Directed table; register rows carry the index in req and the value in cap
        add_row(ROW_ITEM, REQ_SOLVE, 0, 0, 0, 1, 0, ST_OK);      // empty graph after reset
        add_row(ROW_ITEM, REQ_ADD, 0, 1, 16'hffff, 1, 0, ST_OK);
        add_row(ROW_ITEM, REQ_ADD, 0, 1, 16'h0001, 1, 0, ST_SAT);
        add_row(ROW_ITEM, REQ_ADD, 0, 2, 300, 0, 0, 0);
        add_row(ROW_ITEM, REQ_ADD, 2, 1, 200, 0, 0, 0);
        add_row(ROW_ITEM, REQ_ADD, 3, 3, 7, 0, 0, 0);            // self loop
        add_row(ROW_ITEM, REQ_ADD, 15, 15, 0, 0, 0, 0);
        add_row(ROW_ITEM, REQ_ADD, 15, 1, 9, 0, 0, 0);
        add_row(ROW_ITEM, REQ_SOLVE, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, 2'd3, 4'hf, 4'hf, 16'hffff, 1, 0, ST_OK); // unused type
        add_row(ROW_CFG, REG_COUNT, 0, 0, 4, 0, 0, 0);
        add_row(ROW_ITEM, REQ_ADD, 15, 0, 1, 1, 0, ST_BADE);
        add_row(ROW_ITEM, REQ_ADD, 0, 9, 1, 1, 0, ST_BADE);
        add_row(ROW_CFG, REG_SINK, 0, 0, 9, 0, 0, 0);
        add_row(ROW_ITEM, REQ_SOLVE, 0, 0, 0, 1, 0, ST_BADS);
        add_row(ROW_CFG, REG_SINK, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, REQ_SOLVE, 0, 0, 0, 1, 0, ST_OK);      // source equals sink
        add_row(ROW_CFG, REG_COUNT, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, REQ_ADD, 0, 0, 1, 1, 0, ST_BADE);
        add_row(ROW_ITEM, REQ_SOLVE, 0, 0, 0, 1, 0, ST_BADS);
        add_row(ROW_CFG, REG_COUNT, 0, 0, 31, 0, 0, 0);          // saturates to full size
        add_row(ROW_CFG, REG_SINK, 0, 0, 15, 0, 0, 0);
        add_row(ROW_ITEM, REQ_SOLVE, 0, 0, 0, 0, 0, 0);
        add_row(ROW_ITEM, REQ_CLEAR, 0, 0, 0, 1, 0, ST_OK);
        add_row(ROW_ITEM, REQ_SOLVE, 0, 0, 0, 1, 0, ST_OK);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (table_q[i]) begin
            if (table_q[i].kind == ROW_CFG) begin
                drain();
                write_reg(table_q[i].reg_idx, table_q[i].reg_val);
            end else begin
                send_item(table_q[i].req, table_q[i].from_v, table_q[i].to_v,
                          table_q[i].cap, table_q[i].known, table_q[i].res);
            end
        end

        // Random phases: new register setting per phase, then mostly well-formed edges
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p)
                0:       cnt_v = 1;
                1:       cnt_v = 2;
                2:       cnt_v = 16;
                3:       cnt_v = 0;
                4:       cnt_v = 31;
                default: cnt_v = (p % 5 == 0) ? 16 : $urandom_range(2, 8);
            endcase
            calm = (p % 4 == 3);
            write_reg(REG_COUNT, 5'(cnt_v));
            n = (cnt_v > NV) ? NV : cnt_v;
            if (p == 2) begin
                write_reg(REG_SOURCE, 5'd15);
                write_reg(REG_SINK, 5'd0);
            end else if (n > 1 && $urandom_range(0, 5) != 0) begin
                write_reg(REG_SOURCE, 5'($urandom_range(0, n - 1)));
                write_reg(REG_SINK, 5'($urandom_range(0, n - 1)));
            end else begin
                write_reg(REG_SOURCE, 5'($urandom_range(0, 15)));
                write_reg(REG_SINK, 5'($urandom_range(0, 15)));
            end
            send_item(REQ_CLEAR, 4'($urandom), 4'($urandom), 16'($urandom), 0, none);
            for (int k = 0; k < PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                fv = (n > 0) ? 4'($urandom_range(0, n - 1)) : 4'd0;
                tv = (n > 0) ? 4'($urandom_range(0, n - 1)) : 4'd0;
                cap = 16'($urandom);
                case ($urandom_range(0, 3))
                    0: cap = cap & 16'h00ff;
                    1: cap = 16'hffff - cap[3:0];
                    default: ;
                endcase
                if (pick < 75) begin
                    req = REQ_ADD;
                end else if (pick < 85) begin
                    req = REQ_SOLVE;
                end else if (pick < 87) begin
                    req = REQ_CLEAR;
                end else if (pick < 89) begin
                    req = 2'd3;
                end else begin
                    req = REQ_ADD;      // raw indices, often out of range
                    fv = 4'($urandom);
                    tv = 4'($urandom);
                end
                if (k == 30 && p == 6) drain();   // pause until all results are back
                send_item(req, fv, tv, cap, 0, none);
            end
            send_item(REQ_SOLVE, 4'($urandom), 4'($urandom), 16'($urandom), 0, none);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d results, %0d solves, %0d saturated adds, %0d bad indices",
                 got_cnt, solve_cnt, sat_cnt, bad_cnt);
        if (fail_cnt == 0 && pending_q.size() == 0) begin
            $display("max_flow_edmonds_karp: match");
        end else begin
            $display("max_flow_edmonds_karp: mismatch");
        end
        $finish;
    end
endmodule
